// ===== rtl/msu_pkg.sv =====
// ----------------------------------------------------------------------------
// msu_pkg
// Shared types, constants and elaboration helpers for the Metropolis spin
// update block.
// ----------------------------------------------------------------------------
`default_nettype none

package msu_pkg;

  // Item field widths
  localparam int unsigned SITE_W    = 14;
  localparam int unsigned RAND_W    = 16;
  localparam int unsigned MAG_W     = 16;
  localparam int unsigned THR_W     = 16;

  // Stream word widths (fields packed from bit 0, padded to bytes)
  localparam int unsigned S_TDATA_W = 32;  // site, rand_accept
  localparam int unsigned M_TDATA_W = 24;  // flipped, spin_now, mag_sum

  // Command carried in tuser
  localparam logic CMD_UPDATE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Acceptance threshold registers
  localparam int unsigned NUM_THR   = 4;
  localparam int unsigned THR_IDX_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Number of sites the site field can name
  localparam longint unsigned SITE_SPAN = 64'd16384;

  // Width of a raw neighbor index (site plus the largest wrap offset)
  localparam int unsigned IDX_W     = 34;

  // Width of the reciprocal and of the clamped divisor
  localparam int unsigned DIV_W     = 15;

  // Agreement counter width (up to 8 neighbors)
  localparam int unsigned AGREE_W   = 4;

  // One lane's neighbor pair, handed from the address unit to control
  typedef struct packed {
    logic [IDX_W-1:0] up;
    logic [IDX_W-1:0] dn;
    logic             up_in;   // up index lies inside the spin store
    logic             dn_in;   // down index lies inside the spin store
  } nbr_t;

  // base ** expo, evaluated at elaboration
  function automatic longint unsigned ipow(input longint unsigned base,
                                           input int unsigned expo);
    longint unsigned acc;
    int unsigned     i;
    acc = 64'd1;
    for (i = 0; i < expo; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // Spin store depth: lattice size, capped at what the site field can name
  function automatic longint unsigned store_depth(input longint unsigned side,
                                                  input int unsigned dims);
    longint unsigned n;
    n = ipow(side, dims);
    return (n < SITE_SPAN) ? n : SITE_SPAN;
  endfunction

endpackage : msu_pkg

`default_nettype wire

// ===== rtl/msu_ram.sv =====
// ----------------------------------------------------------------------------
// msu_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msu_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr_i,
  output      logic [WIDTH-1:0]         ra_data_o,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output      logic [WIDTH-1:0]         rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, registered
  always_ff @(posedge clk_i) begin
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule : msu_ram

`default_nettype wire

// ===== rtl/msu_nbr.sv =====
// ----------------------------------------------------------------------------
// msu_nbr
// Neighbor address unit: one lane per lattice axis. Each lane takes the
// site index modulo SIDE^(j+1) by reciprocal multiply and one correction,
// finds the wrap cases from that remainder and forms the up and down
// neighbor indexes. Three register stages: product, remainder, neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module msu_nbr
  import msu_pkg::*;
#(
  parameter int unsigned SIDE = 128,
  parameter int unsigned DIMS = 2
) (
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic [SITE_W-1:0] site_i,
  output      logic [SITE_W-1:0] site_o,
  output      nbr_t              nbr_o [DIMS]
);

  localparam longint unsigned DEPTH = store_depth(SIDE, DIMS);
  localparam int unsigned     PW    = SITE_W + DIV_W;

  logic [SITE_W-1:0] site_q;

  // Site register, held for the whole update
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      site_q <= site_i;
    end
  end

  assign site_o = site_q;

  for (genvar j = 0; j < DIMS; j++) begin : g_lane
    localparam longint unsigned STRIDE = ipow(SIDE, j);
    localparam longint unsigned DIVR   = ipow(SIDE, j + 1);
    localparam longint unsigned DEFF   = (DIVR < SITE_SPAN) ? DIVR : SITE_SPAN;
    localparam longint unsigned RECIP  = SITE_SPAN / DEFF;
    localparam longint unsigned HI     = (SIDE - 1) * STRIDE;

    logic [PW-1:0]     p_q;
    logic [DIV_W-1:0]  quot;
    logic [PW-1:0]     rem_raw;
    logic [PW-1:0]     rem_fix;
    logic [SITE_W-1:0] m_q;
    logic [IDX_W-1:0]  s_ext;
    logic [IDX_W-1:0]  m_ext;
    nbr_t              nbr_d;
    nbr_t              nbr_q;

    // Stage 1: site times reciprocal (quotient estimate, low by at most one)
    always_ff @(posedge clk_i) begin
      if (load_i) begin
        p_q <= {{DIV_W{1'b0}}, site_i} * PW'(RECIP);
      end
    end

    // Stage 2: remainder with one correction step
    assign quot    = p_q[PW-1:SITE_W];
    assign rem_raw = {{DIV_W{1'b0}}, site_q} - ({{SITE_W{1'b0}}, quot} * PW'(DEFF));
    assign rem_fix = (rem_raw >= PW'(DEFF)) ? (rem_raw - PW'(DEFF)) : rem_raw;

    always_ff @(posedge clk_i) begin
      m_q <= rem_fix[SITE_W-1:0];
    end

    // Stage 3: wrapped neighbor indexes
    assign s_ext = IDX_W'(site_q);
    assign m_ext = IDX_W'(m_q);

    always_comb begin
      nbr_d       = '0;
      // coordinate at SIDE-1 wraps up to 0
      nbr_d.up    = (m_ext >= IDX_W'(HI)) ? (s_ext - IDX_W'(HI))
                                          : (s_ext + IDX_W'(STRIDE));
      // coordinate at 0 wraps down to SIDE-1
      nbr_d.dn    = (m_ext < IDX_W'(STRIDE)) ? (s_ext + IDX_W'(HI))
                                             : (s_ext - IDX_W'(STRIDE));
      nbr_d.up_in = (nbr_d.up < IDX_W'(DEPTH));
      nbr_d.dn_in = (nbr_d.dn < IDX_W'(DEPTH));
    end

    always_ff @(posedge clk_i) begin
      nbr_q <= nbr_d;
    end

    assign nbr_o[j] = nbr_q;
  end

endmodule : msu_nbr

`default_nettype wire

// ===== rtl/metropolis_ising_spin_update.sv =====
// ----------------------------------------------------------------------------
// metropolis_ising_spin_update
// Metropolis single-site update on a periodic hypercubic Ising lattice with
// a running magnetization sum.
// ----------------------------------------------------------------------------
// Spins live in a one-bit-wide dual-read RAM of min(SIDE^DIMS, 16384)
// entries; sites beyond that depth read as +1. An update word reads the
// site on accept, forms the neighbor indexes in a three-stage address unit,
// then reads two neighbors per cycle on the two RAM read ports, decides the
// flip and writes the site back. An update passes through the site read,
// the neighbor address stages, one neighbor pair per axis, the decision and
// the output register, and the next word can be accepted at the same edge as
// its earliest result handshake. A site beyond the store, or a restart word,
// goes from accept straight to the done state and gives its result from
// there. After reset, and after every restart word, the RAM is swept to all
// ones, one entry per cycle, and no word is accepted during the sweep.
// Threshold writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module metropolis_ising_spin_update
  import msu_pkg::*;
#(
  parameter int unsigned SIDE = 128,
  parameter int unsigned DIMS = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // update words
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // site[13:0], rand_accept[29:14]
  input  wire logic                 s_axis_tuser,   // cmd[0]
  // result words
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [M_TDATA_W-1:0] m_axis_tdata,   // flipped[0], spin_now[1],
                                                    // mag_sum[17:2]
  // threshold writes
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [THR_W-1:0]     cfg_data_i
);

  localparam longint unsigned NSITES = ipow(SIDE, DIMS);
  localparam longint unsigned DEPTH  = store_depth(SIDE, DIMS);
  localparam int unsigned     AW     = $clog2(DEPTH);
  localparam int unsigned     RC_W   = (DIMS > 1) ? $clog2(DIMS) : 1;

  // Control states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_NBR   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DEC   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [RC_W-1:0]    rc_q, rc_d;
  logic [AGREE_W-1:0] agree_q, agree_d;
  logic [MAG_W-1:0]   total_q, total_d;
  logic               restart_q, restart_d;
  logic               spin_q;
  logic               oka_q, okb_q;
  logic [RAND_W-1:0]  rand_q;
  logic               res_flip_q, res_flip_d;
  logic               res_spin_q, res_spin_d;
  logic [THR_W-1:0]   thr_q [NUM_THR];

  logic               out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;

  // Input word fields
  logic              in_cmd;
  logic [SITE_W-1:0] in_site;
  logic [RAND_W-1:0] in_rand;
  logic              in_acc;

  assign in_cmd  = s_axis_tuser;
  assign in_site = s_axis_tdata[SITE_W-1:0];
  assign in_rand = s_axis_tdata[SITE_W +: RAND_W];
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // Neighbor address unit
  // --------------------------------------------------------------------------
  logic [SITE_W-1:0] site_q;
  nbr_t              nbr [DIMS];

  msu_nbr #(
    .SIDE (SIDE),
    .DIMS (DIMS)
  ) u_nbr (
    .clk_i  (clk_i),
    .load_i (in_acc),
    .site_i (in_site),
    .site_o (site_q),
    .nbr_o  (nbr)
  );

  // --------------------------------------------------------------------------
  // Spin store
  // --------------------------------------------------------------------------
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ra_addr, rb_addr;
  logic          ra_data, rb_data;

  msu_ram #(
    .WIDTH (1),
    .DEPTH (32'(DEPTH))
  ) u_spin_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .ra_addr_i (ra_addr),
    .ra_data_o (ra_data),
    .rb_addr_i (rb_addr),
    .rb_data_o (rb_data)
  );

  // Site read on accept, neighbor pairs afterwards
  assign ra_addr = (state_q == ST_IDLE) ? in_site[AW-1:0] : nbr[rc_q].up[AW-1:0];
  assign rb_addr = nbr[rc_q].dn[AW-1:0];

  // --------------------------------------------------------------------------
  // Acceptance decision
  // --------------------------------------------------------------------------
  logic                 a_eff, b_eff;
  logic [AGREE_W-1:0]   pair_agree;
  logic [AGREE_W-1:0]   agree_tot;
  logic [AGREE_W-1:0]   k_idx;
  logic                 flip;
  logic                 site_out;

  // Neighbors outside the store count as +1
  assign a_eff      = oka_q ? ra_data : 1'b1;
  assign b_eff      = okb_q ? rb_data : 1'b1;
  assign pair_agree = AGREE_W'(a_eff == spin_q) + AGREE_W'(b_eff == spin_q);
  assign agree_tot  = agree_q + pair_agree;

  // k = agree - DIMS; flip outright when k <= 0
  assign k_idx = agree_tot - AGREE_W'(DIMS) - AGREE_W'(1);
  assign flip  = (agree_tot <= AGREE_W'(DIMS)) ||
                 (rand_q < thr_q[k_idx[THR_IDX_W-1:0]]);

  assign site_out = ({1'b0, in_site} >= (SITE_W + 1)'(DEPTH));

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  logic slot_free;
  logic out_load;

  assign slot_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    rc_d       = rc_q;
    agree_d    = agree_q;
    total_d    = total_q;
    restart_d  = restart_q;
    res_flip_d = res_flip_q;
    res_spin_d = res_spin_q;
    ram_we     = 1'b0;
    ram_waddr  = site_q[AW-1:0];
    ram_wdata  = !spin_q;
    out_load   = 1'b0;

    unique case (state_q)
      // sweep the store to all +1
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 1'b1;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          clr_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          res_flip_d = 1'b0;
          if (in_cmd == CMD_RESTART) begin
            res_spin_d = 1'b1;
            restart_d  = 1'b1;
            total_d    = MAG_W'(NSITES);
            state_d    = ST_DONE;
          end else if (site_out) begin
            res_spin_d = 1'b0;
            state_d    = ST_DONE;
          end else begin
            state_d    = ST_MOD;
          end
        end
      end

      ST_MOD: begin
        state_d = ST_NBR;
      end

      ST_NBR: begin
        rc_d    = '0;
        agree_d = '0;
        state_d = ST_READ;
      end

      // one neighbor pair per cycle; count the pair from the cycle before
      ST_READ: begin
        if (rc_q != '0) begin
          agree_d = agree_tot;
        end
        rc_d = rc_q + RC_W'(1);
        if (rc_q == RC_W'(DIMS - 1)) begin
          state_d = ST_DEC;
        end
      end

      ST_DEC: begin
        ram_we     = flip;
        res_flip_d = flip;
        res_spin_d = spin_q ^ flip;
        if (flip) begin
          total_d = spin_q ? (total_q - MAG_W'(2)) : (total_q + MAG_W'(2));
        end
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d  = ST_DONE;
        end
      end

      ST_DONE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          restart_d = 1'b0;
          state_d   = restart_q ? ST_CLEAR : ST_IDLE;
        end
      end

      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rc_q      <= '0;
      agree_q   <= '0;
      total_q   <= MAG_W'(NSITES);
      restart_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rc_q      <= rc_d;
      agree_q   <= agree_d;
      total_q   <= total_d;
      restart_q <= restart_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    res_flip_q <= res_flip_d;
    res_spin_q <= res_spin_d;
    if (in_acc) begin
      rand_q <= in_rand;
    end
    if (state_q == ST_MOD) begin
      spin_q <= ra_data;
    end
    if (state_q == ST_READ) begin
      oka_q <= nbr[rc_q].up_in;
      okb_q <= nbr[rc_q].dn_in;
    end
  end

  // --------------------------------------------------------------------------
  // Threshold registers
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_THR; i++) begin
        thr_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i < CFG_IDX_W'(NUM_THR))) begin
      thr_q[cfg_index_i[THR_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {{(M_TDATA_W - MAG_W - 2){1'b0}}, total_d, res_spin_d, res_flip_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule : metropolis_ising_spin_update

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Metropolis spin update block. A directed table
// covers reset state, extreme thresholds and random values, wrapped edges and
// restarts. Phases of random update words follow, aimed mostly at a small
// wrapped patch of the lattice so that neighbors interact. Every result word
// is checked against a local lattice predictor or a fixed expected value.
// ----------------------------------------------------------------------------
module tb_top;
  import msu_pkg::*;

  localparam int unsigned LAT_SIDE = 128;
  localparam int unsigned LAT_DIMS = 2;
  localparam longint unsigned LAT_TOTAL = longint'(LAT_SIDE) ** LAT_DIMS;
  localparam int unsigned STORE_SITES =
    (LAT_TOTAL < SITE_SPAN) ? int'(LAT_TOTAL) : int'(SITE_SPAN);

  localparam bit [CFG_IDX_W-1:0] REG_DE4      = 3'd0;
  localparam bit [CFG_IDX_W-1:0] REG_DE8      = 3'd1;
  localparam bit [CFG_IDX_W-1:0] REG_DE12     = 3'd2;
  localparam bit [CFG_IDX_W-1:0] REG_DE16     = 3'd3;
  localparam bit [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

  localparam int NUM_PHASES     = 6;
  localparam int WORDS_PER_PHASE = 122;
  localparam int MAX_RESTARTS   = 12;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 16;
  localparam int LIMIT_CYCLES   = 1_200_000;

  typedef struct packed {
    bit             flipped;
    bit             spin_now;
    bit [MAG_W-1:0] mag;
  } spin_result_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    bit                 cmd;
    bit [SITE_W-1:0]    site;
    bit [RAND_W-1:0]    rnd;
    bit [CFG_IDX_W-1:0] reg_idx;
    bit [THR_W-1:0]     reg_val;
    bit                 typed;
    spin_result_t       want;
  } stim_row_t;

  localparam spin_result_t NO_RES     = '0;
  localparam spin_result_t ALL_UP     = '{1'b0, 1'b1, 16'd16384};
  localparam spin_result_t FIRST_FLIP = '{1'b1, 1'b0, 16'd16382};

  // Directed rows: fixed expectations only where obvious, rest predicted
  localparam stim_row_t DIRECTED [24] = '{
    '{ROW_ITEM, CMD_UPDATE,  14'd0,     16'h0000, REG_DE4, 16'h0000, 1'b1, ALL_UP},
    '{ROW_ITEM, CMD_UPDATE,  14'd16383, 16'hFFFF, REG_DE4, 16'h0000, 1'b1, ALL_UP},
    '{ROW_ITEM, CMD_RESTART, 14'd16383, 16'hFFFF, REG_DE4, 16'h0000, 1'b1, ALL_UP},
    '{ROW_CFG,  CMD_UPDATE,  14'd0, 16'h0000, REG_DE4,      16'hFFFF, 1'b0, NO_RES},
    '{ROW_CFG,  CMD_UPDATE,  14'd0, 16'h0000, REG_DE8,      16'hFFFF, 1'b0, NO_RES},
    '{ROW_CFG,  CMD_UPDATE,  14'd0, 16'h0000, REG_DE12,     16'h1234, 1'b0, NO_RES},
    '{ROW_CFG,  CMD_UPDATE,  14'd0, 16'h0000, REG_DE16,     16'hFFFF, 1'b0, NO_RES},
    '{ROW_CFG,  CMD_UPDATE,  14'd0, 16'h0000, REG_UNMAPPED, 16'h0000, 1'b0, NO_RES},
    // top threshold still rejects the top random value
    '{ROW_ITEM, CMD_UPDATE,  14'd0,     16'hFFFF, REG_DE4, 16'h0000, 1'b1, ALL_UP},
    '{ROW_ITEM, CMD_UPDATE,  14'd0,     16'h0000, REG_DE4, 16'h0000, 1'b1, FIRST_FLIP},
    '{ROW_ITEM, CMD_UPDATE,  14'd1,     16'hFFFE, REG_DE4, 16'h0000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_UPDATE,  14'd0,     16'hFFFF, REG_DE4, 16'h0000, 1'b0, NO_RES},
    // wrapped edges: x, y and both
    '{ROW_ITEM, CMD_UPDATE,  14'd127,   16'h0000, REG_DE4, 16'h0000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_UPDATE,  14'd16256, 16'h0000, REG_DE4, 16'h0000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_UPDATE,  14'd16383, 16'h0000, REG_DE4, 16'h0000, 1'b0, NO_RES},
    // surround site 129 with down spins, then flip it downhill
    '{ROW_ITEM, CMD_UPDATE,  14'd128,   16'h0000, REG_DE4, 16'h0000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_UPDATE,  14'd130,   16'h0000, REG_DE4, 16'h0000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_UPDATE,  14'd257,   16'h0000, REG_DE4, 16'h0000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_UPDATE,  14'd129,   16'hFFFF, REG_DE4, 16'h0000, 1'b0, NO_RES},
    '{ROW_CFG,  CMD_UPDATE,  14'd0, 16'h0000, REG_DE4,      16'h0000, 1'b0, NO_RES},
    '{ROW_CFG,  CMD_UPDATE,  14'd0, 16'h0000, REG_DE8,      16'h0000, 1'b0, NO_RES},
    // uphill rejected with zero threshold; zero field flips anyway
    '{ROW_ITEM, CMD_UPDATE,  14'd129,   16'h0000, REG_DE4, 16'h0000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_UPDATE,  14'd2,     16'h0000, REG_DE4, 16'h0000, 1'b0, NO_RES},
    '{ROW_ITEM, CMD_RESTART, 14'd0,     16'h0000, REG_DE4, 16'h0000, 1'b1, ALL_UP}
  };

  // DUT ports
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // site[13:0], rand_accept[29:14]
  logic                 s_axis_tuser  = 1'b0; // cmd[0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;         // flipped[0], spin_now[1], mag_sum[17:2]
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [THR_W-1:0]     cfg_data_i    = '0;

  // Predictor state
  bit             lattice_spins [STORE_SITES];
  longint         mag_total;
  bit [THR_W-1:0] accept_thr [NUM_THR];

  spin_result_t results_due [$];

  // Bench control and bookkeeping
  bit gaps_on  = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int err_count = 0;
  int results_checked = 0;
  int updates_sent = 0;
  int restarts_sent = 0;
  int flips_seen = 0;
  int cfg_writes = 0;

  metropolis_ising_spin_update #(
    .SIDE(LAT_SIDE),
    .DIMS(LAT_DIMS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Spin of any lattice index; sites beyond the store read as up
  function automatic int site_spin(longint unsigned idx);
    if (idx < STORE_SITES) begin
      return lattice_spins[idx] ? 1 : -1;
    end
    return 1;
  endfunction

  // One Metropolis step on the local lattice copy
  function automatic spin_result_t metropolis_step(bit cmd, bit [SITE_W-1:0] site,
                                                   bit [RAND_W-1:0] rnd);
    spin_result_t    res;
    longint unsigned stride, coord, up, dn;
    int              field, s, k, j;
    bit              flip;
    res = '0;
    if (cmd == CMD_RESTART) begin
      foreach (lattice_spins[i]) lattice_spins[i] = 1'b1;
      mag_total = LAT_TOTAL;
      res.spin_now = 1'b1;
    end else if (site < STORE_SITES) begin
      s = site_spin(site);
      field = 0;
      stride = 1;
      for (j = 0; j < LAT_DIMS; j++) begin
        coord = (site / stride) % LAT_SIDE;
        up = (coord == LAT_SIDE - 1) ? site - (LAT_SIDE - 1) * stride : site + stride;
        dn = (coord == 0) ? site + (LAT_SIDE - 1) * stride : site - stride;
        field += site_spin(up) + site_spin(dn);
        stride *= LAT_SIDE;
      end
      // energy rise is 4k; downhill and flat moves always flip
      k = (s * field) / 2;
      if (k <= 0) begin
        flip = 1'b1;
      end else if (k <= NUM_THR) begin
        flip = rnd < accept_thr[k-1];
      end else begin
        flip = 1'b0;
      end
      if (flip) begin
        lattice_spins[site] = ~lattice_spins[site];
        mag_total += (s > 0) ? -2 : 2;
        res.flipped = 1'b1;
        flips_seen++;
      end
      res.spin_now = lattice_spins[site];
    end
    res.mag = MAG_W'(mag_total);
    return res;
  endfunction

  // Offer one update word; predict once it is taken
  task automatic send_word(bit cmd, bit [SITE_W-1:0] site, bit [RAND_W-1:0] rnd,
                           bit typed, spin_result_t typed_res);
    spin_result_t res;
    while (gaps_on && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, rnd, site};
    do @(posedge clk_i); while (!s_axis_tready);
    res = metropolis_step(cmd, site, rnd);
    results_due = {results_due, (typed ? typed_res : res)};
    if (cmd == CMD_RESTART) restarts_sent++;
    else updates_sent++;
  endtask

  // Stop offering and let every outstanding result come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [THR_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_THR) accept_thr[idx] = val;
    cfg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      stall_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 19);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    spin_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result word 0x%h with nothing expected", $time, m_axis_tdata);
        err_count++;
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (m_axis_tdata[0] !== want.flipped) begin
          $display("%0t: flipped expected %0d, got %0d", $time, want.flipped,
                   m_axis_tdata[0]);
          err_count++;
        end
        if (m_axis_tdata[1] !== want.spin_now) begin
          $display("%0t: spin_now expected %0d, got %0d", $time, want.spin_now,
                   m_axis_tdata[1]);
          err_count++;
        end
        if (m_axis_tdata[17:2] !== want.mag) begin
          $display("%0t: mag_sum expected %0d, got %0d", $time, $signed(want.mag),
                   $signed(m_axis_tdata[17:2]));
          err_count++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus
  initial begin
    bit              cmd;
    bit [SITE_W-1:0] site;
    bit [RAND_W-1:0] rnd;
    bit [THR_W-1:0]  thr_plan [NUM_THR];
    int              x, y, pick, restarts_left, phase, r;
    foreach (lattice_spins[i]) lattice_spins[i] = 1'b1;
    mag_total = LAT_TOTAL;
    foreach (accept_thr[i]) accept_thr[i] = '0;
    restarts_left = MAX_RESTARTS;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        send_word(DIRECTED[i].cmd, DIRECTED[i].site, DIRECTED[i].rnd,
                  DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // Random phases, each under its own threshold setting
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      foreach (thr_plan[i]) thr_plan[i] = THR_W'($urandom);
      case (phase)
        0: begin
          thr_plan[REG_DE4] = '0;
          thr_plan[REG_DE8] = '0;
        end
        1: foreach (thr_plan[i]) thr_plan[i] = '1;
        3: begin
          thr_plan[REG_DE4] = '1;
          thr_plan[REG_DE8] = '0;
        end
        5: begin
          thr_plan[REG_DE4] = '0;
          thr_plan[REG_DE8] = '1;
        end
        default: ;
      endcase
      for (r = 0; r < NUM_THR; r++) write_reg(CFG_IDX_W'(r), thr_plan[r]);
      if (phase % 2 == 1) write_reg(CFG_IDX_W'($urandom_range(4, 7)), THR_W'($urandom));

      // one stretch with no idling; one long hold-off on the result side
      gaps_on = (phase != 1);
      if (phase == 3) hold_req = 1'b1;

      repeat (WORDS_PER_PHASE) begin
        cmd = CMD_UPDATE;
        if (restarts_left > 0 && $urandom_range(0, 99) < 2) begin
          cmd = CMD_RESTART;
          restarts_left--;
        end
        // mostly a 6x6 patch straddling both wrapped edges
        if ($urandom_range(0, 99) < 80) begin
          x = (LAT_SIDE - 2 + $urandom_range(0, 5)) % LAT_SIDE;
          y = (LAT_SIDE - 2 + $urandom_range(0, 5)) % LAT_SIDE;
          site = SITE_W'(y * LAT_SIDE + x);
        end else begin
          site = SITE_W'($urandom_range(0, STORE_SITES - 1));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) rnd = '0;
        else if (pick < 20) rnd = '1;
        else if (pick < 35)
          rnd = accept_thr[$urandom_range(0, 1)] + RAND_W'($urandom_range(0, 2)) - 1'b1;
        else rnd = RAND_W'($urandom);
        send_word(cmd, site, rnd, 1'b0, NO_RES);
      end
    end

    wait_drained();
    gaps_on = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Summary: %0d update words and %0d restarts sent, %0d threshold writes",
             updates_sent, restarts_sent, cfg_writes);
    $display("Summary: %0d results checked, %0d spin flips predicted",
             results_checked, flips_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/msu_pkg.sv
rtl/msu_ram.sv
rtl/msu_nbr.sv
rtl/metropolis_ising_spin_update.sv
verif/tb_top.sv
